@@ sv/gmvn_pkg.sv @@
`default_nettype none
package gmvn_pkg;

   localparam int DEF_RING_ROWS    = 8;
   localparam int DEF_RING_COLUMNS = 32;

   localparam int STORE_DEPTH = 256;
   localparam int ADDR_W      = 8;
   localparam int COORD_W     = 13;
   localparam int VTX_W       = 3 * COORD_W;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int ACC_W       = 31;
   localparam int SQ_W        = 2 * ACC_W;
   localparam int LEN_W       = SQ_W + 2;
   localparam int SCALE_SH    = 14;
   localparam int QUOT_W      = SCALE_SH + 1;
   localparam int DIV_W       = LEN_W + SCALE_SH + 2;
   localparam int LIN_W       = 13;
   localparam int NORM_W      = 8;
   localparam int NSLOT       = 8;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CROSS,
      ST_SQUARE,
      ST_DIVIDE,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

@@ sv/grid_mesh_vertex_normals.sv @@
// write beat: accepted while idle and stored the same cycle
// read beat: the result is registered into the response slot, and the next beat is taken back in idle;
// vertex fetch of eight slots from the single ram port, 12 cross-product steps, 3 squares,
// per component a restoring divide and a square root, then the load of the response
// one read in flight at a time; writes are taken while a result waits
// synchronous reset clears control state only; vertex ram is undefined until written
`default_nettype none
module grid_mesh_vertex_normals
   import gmvn_pkg::*;
#(
   parameter int RING_ROWS    = DEF_RING_ROWS,
   parameter int RING_COLUMNS = DEF_RING_COLUMNS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // vertex_index, pos_x, pos_y, pos_z, zero pad
   input  wire logic [47:0] req_tdata,
   // req_type
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_index, norm_x, norm_y, norm_z
   output logic [31:0]      rsp_tdata
);

   localparam int ROW_W = $clog2(RING_ROWS);
   localparam int COL_W = $clog2(RING_COLUMNS);
   localparam int GRID_TOTAL = RING_ROWS * RING_COLUMNS;

   state_type state_ff, state_in;

   logic [3:0]               cnt_ff;
   logic [1:0]               comp_ff;
   logic [1:0]               quad_ff;
   logic [ROW_W-1:0]         row_ff;
   logic [COL_W-1:0]         col_ff;
   logic [ADDR_W-1:0]        read_idx_ff;
   logic                     slot_zero_ff;
   logic [VTX_W-1:0]         vtx_ff [NSLOT];
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic [SQ_W-1:0]          sq_ff [3];
   logic [LEN_W-1:0]         len_ff;
   logic [DIV_W-1:0]         rem_ff;
   logic [QUOT_W-1:0]        quot_ff;
   logic [NORM_W-1:0]        q_ff;
   logic [NORM_W-1:0]        norm_ff [3];
   logic                     rsp_valid_ff;
   logic [31:0]              rsp_data_ff;

   logic                     req_beat, rsp_free, in_grid, ram_rd_en, ram_wr_en;
   logic [ADDR_W-1:0]        req_idx, ram_addr;
   logic [VTX_W-1:0]         ram_rdata;

   assign req_idx  = req_tdata[7:0];
   assign req_beat = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign in_grid  = 32'(req_idx) < 32'(GRID_TOTAL);

   // row and column of the requested index
   logic [15:0]      dv_rem;
   logic [7:0]       dv_quo;
   always_comb begin
      dv_rem = 16'(req_idx);
      dv_quo = '0;
      for (int k = 7; k >= 0; k--) begin
         if (dv_rem >= (16'(RING_COLUMNS) << k)) begin
            dv_rem    = dv_rem - (16'(RING_COLUMNS) << k);
            dv_quo[k] = 1'b1;
         end
      end
   end

   logic [ROW_W-1:0] row_p, row_n;
   logic [COL_W-1:0] col_p, col_n;
   assign row_p = (row_ff == '0) ? ROW_W'(RING_ROWS - 1) : row_ff - ROW_W'(1);
   assign row_n = (row_ff == ROW_W'(RING_ROWS - 1)) ? '0 : row_ff + ROW_W'(1);
   assign col_p = (col_ff == '0) ? COL_W'(RING_COLUMNS - 1) : col_ff - COL_W'(1);
   assign col_n = (col_ff == COL_W'(RING_COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);

   // fetch slot address
   logic [ROW_W-1:0] slot_row;
   logic [COL_W-1:0] slot_col;
   logic [LIN_W-1:0] slot_lin;
   logic             slot_oos;
   always_comb begin
      unique case (cnt_ff[2:0])
         3'd0: begin slot_row = row_ff; slot_col = col_ff; end
         3'd1: begin slot_row = row_n;  slot_col = col_ff; end
         3'd2: begin slot_row = row_n;  slot_col = col_n;  end
         3'd3: begin slot_row = row_ff; slot_col = col_p;  end
         3'd4: begin slot_row = row_n;  slot_col = col_p;  end
         3'd5: begin slot_row = row_p;  slot_col = col_ff; end
         3'd6: begin slot_row = row_ff; slot_col = col_n;  end
         default: begin slot_row = row_p; slot_col = col_p; end
      endcase
   end
   assign slot_lin = LIN_W'(slot_row) * LIN_W'(RING_COLUMNS) + LIN_W'(slot_col);
   assign slot_oos = 32'(slot_lin) >= 32'(STORE_DEPTH);

   assign ram_wr_en = req_beat && (req_tuser == REQ_WRITE) && in_grid;
   assign ram_addr  = (state_ff == ST_IDLE) ? req_idx : slot_lin[ADDR_W-1:0];

   gmvn_ram #(
      .WIDTH(VTX_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (req_tdata[8 +: VTX_W]),
      .rd_en   (ram_rd_en),
      .rd_data (ram_rdata)
   );

   // quad corners
   logic [VTX_W-1:0] p0, p4, p3;
   always_comb begin
      unique case (quad_ff)
         2'd0: begin p0 = vtx_ff[0]; p4 = vtx_ff[1]; p3 = vtx_ff[2]; end
         2'd1: begin p0 = vtx_ff[3]; p4 = vtx_ff[4]; p3 = vtx_ff[1]; end
         2'd2: begin p0 = vtx_ff[5]; p4 = vtx_ff[0]; p3 = vtx_ff[6]; end
         default: begin p0 = vtx_ff[7]; p4 = vtx_ff[3]; p3 = vtx_ff[0]; end
      endcase
   end

   logic signed [DIFF_W-1:0] da [3];
   logic signed [DIFF_W-1:0] db [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         da[k] = DIFF_W'($signed(p3[k*COORD_W +: COORD_W]))
               - DIFF_W'($signed(p4[k*COORD_W +: COORD_W]));
         db[k] = DIFF_W'($signed(p0[k*COORD_W +: COORD_W]))
               - DIFF_W'($signed(p4[k*COORD_W +: COORD_W]));
      end
   end

   logic signed [DIFF_W-1:0]   m1a, m1b, m2a, m2b;
   logic signed [2*DIFF_W:0]   cross_term;
   always_comb begin
      unique case (comp_ff)
         2'd0: begin m1a = da[1]; m1b = db[2]; m2a = da[2]; m2b = db[1]; end
         2'd1: begin m1a = da[2]; m1b = db[0]; m2a = da[0]; m2b = db[2]; end
         default: begin m1a = da[0]; m1b = db[1]; m2a = da[1]; m2b = db[0]; end
      endcase
   end
   assign cross_term = (2*DIFF_W+1)'(m1a) * (2*DIFF_W+1)'(m1b)
                     - (2*DIFF_W+1)'(m2a) * (2*DIFF_W+1)'(m2b);

   logic [ACC_W-1:0] mag;
   logic [SQ_W-1:0]  sq_prod;
   assign mag     = acc_ff[comp_ff][ACC_W-1] ? ACC_W'(-acc_ff[comp_ff])
                                             : ACC_W'(acc_ff[comp_ff]);
   assign sq_prod = SQ_W'(mag) * SQ_W'(mag);

   logic [LEN_W-1:0] len_eff;
   logic [DIV_W-1:0] dsub;
   logic             dge;
   assign len_eff = (len_ff == '0) ? LEN_W'(1) : len_ff;
   assign dsub    = DIV_W'(len_eff) << cnt_ff;
   assign dge     = rem_ff >= dsub;

   logic [NORM_W-1:0] trial, q_next, norm_val;
   logic [15:0]       trial_sq;
   assign trial    = q_ff | (NORM_W'(1) << cnt_ff[2:0]);
   assign trial_sq = 16'(trial) * 16'(trial);
   assign q_next   = (trial_sq <= 16'(quot_ff)) ? trial : q_ff;
   assign norm_val = acc_ff[comp_ff][ACC_W-1] ? NORM_W'(-q_next)
                   : (q_next[NORM_W-1] ? NORM_W'(127) : q_next);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_tuser == REQ_READ)) begin
               state_in = in_grid ? ST_FETCH : ST_DONE;
            end
         end
         ST_FETCH:  if (cnt_ff == 4'(NSLOT)) state_in = ST_CROSS;
         ST_CROSS:  if (quad_ff == 2'd3 && comp_ff == 2'd2) state_in = ST_SQUARE;
         ST_SQUARE: if (comp_ff == 2'd2) state_in = ST_DIVIDE;
         ST_DIVIDE: if (cnt_ff == 4'd0) state_in = ST_ROOT;
         ST_ROOT: begin
            if (cnt_ff == 4'd0) begin
               state_in = (comp_ff == 2'd2) ? ST_DONE : ST_DIVIDE;
            end
         end
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      ram_rd_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_FETCH: ram_rd_en  = cnt_ff < 4'(NSLOT);
         default: begin
            req_tready = 1'b0;
            ram_rd_en  = 1'b0;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         quad_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff  <= '0;
               comp_ff <= '0;
               quad_ff <= '0;
            end
            ST_FETCH: cnt_ff <= cnt_ff + 4'd1;
            ST_CROSS: begin
               if (comp_ff == 2'd2) begin
                  comp_ff <= '0;
                  quad_ff <= quad_ff + 2'd1;
               end else begin
                  comp_ff <= comp_ff + 2'd1;
               end
            end
            ST_SQUARE: begin
               if (comp_ff == 2'd2) begin
                  comp_ff <= '0;
                  cnt_ff  <= 4'(SCALE_SH);
               end else begin
                  comp_ff <= comp_ff + 2'd1;
               end
            end
            ST_DIVIDE: cnt_ff <= (cnt_ff == 4'd0) ? 4'(NORM_W - 1) : cnt_ff - 4'd1;
            ST_ROOT: begin
               if (cnt_ff == 4'd0) begin
                  cnt_ff  <= 4'(SCALE_SH);
                  comp_ff <= comp_ff + 2'd1;
               end else begin
                  cnt_ff <= cnt_ff - 4'd1;
               end
            end
            default: cnt_ff <= '0;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_tuser == REQ_READ)) begin
               read_idx_ff <= req_idx;
               row_ff      <= dv_quo[ROW_W-1:0];
               col_ff      <= dv_rem[COL_W-1:0];
               len_ff      <= '0;
               for (int k = 0; k < 3; k++) begin
                  acc_ff[k]  <= '0;
                  norm_ff[k] <= '0;
               end
            end
         end
         ST_FETCH: begin
            slot_zero_ff <= slot_oos;
            if (cnt_ff != 4'd0) begin
               vtx_ff[cnt_ff[2:0] - 3'd1] <= slot_zero_ff ? '0 : ram_rdata;
            end
         end
         ST_CROSS: begin
            acc_ff[comp_ff] <= acc_ff[comp_ff] + ACC_W'(cross_term);
         end
         ST_SQUARE: begin
            sq_ff[comp_ff] <= sq_prod;
            len_ff         <= len_ff + LEN_W'(sq_prod);
            if (comp_ff == 2'd2) begin
               rem_ff  <= DIV_W'(sq_ff[0]) << SCALE_SH;
               quot_ff <= '0;
            end
         end
         ST_DIVIDE: begin
            if (dge) begin
               rem_ff          <= rem_ff - dsub;
               quot_ff[cnt_ff] <= 1'b1;
            end
            q_ff <= '0;
         end
         ST_ROOT: begin
            q_ff <= q_next;
            if (cnt_ff == 4'd0) begin
               norm_ff[comp_ff] <= norm_val;
               if (comp_ff != 2'd2) begin
                  rem_ff  <= DIV_W'(sq_ff[comp_ff + 2'd1]) << SCALE_SH;
                  quot_ff <= '0;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_data_ff <= {norm_ff[2], norm_ff[1], norm_ff[0], read_idx_ff};
            end
         end
         default: begin
            q_ff <= q_ff;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ sv/gmvn_ram.sv @@
`default_nettype none
module gmvn_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[addr];
      end
   end

endmodule
`default_nettype wire
